// ===== rtl/pts_pkg.sv =====
// shared types and constants of the priority time-slice scheduler
`default_nettype none
package pts_pkg;

    localparam int OP_W    = 2;
    localparam int PID_W   = 4;
    localparam int NICE_W  = 6;
    localparam int REQ_W   = 8;
    localparam int SLICE_W = 8;
    localparam int TICK_W  = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic signed [NICE_W-1:0] NICE_MAX = 6'sd19;
    localparam logic signed [NICE_W-1:0] NICE_MIN = -6'sd20;
    localparam logic signed [NICE_W-1:0] RST_NICE = 6'sd0;
    localparam logic [SLICE_W-1:0]       RST_SLICE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_NICE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_FORK = 2'd1,
        OP_EXIT = 2'd2,
        OP_NICE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_SLOT = 2'd1,
        ST_REFUSED = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    // per-slot record kept in one memory
    typedef struct packed {
        logic signed [NICE_W-1:0] nice;
        logic [SLICE_W-1:0]       slice;
        logic [TICK_W-1:0]        ticks;
    } t_arec;

    typedef struct packed {
        logic    take;
        logic    rd_cur;
        logic    do_tick;
        logic    do_nice;
        logic    do_exit;
        logic    free_start;
        logic    free_step;
        logic    fork_wr;
        logic    sw_start;
        logic    sw_reload;
        logic    sw_reparent;
        logic    sw_step;
        logic    commit;
        logic    st_we;
        t_status st_code;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic cur_one;
        logic expired;
        logic free_hit;
        logic free_last;
        logic sw_done;
        logic found;
        logic out_busy;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== rtl/pts_intf.sv =====
// channel interfaces: task events, results and configuration writes
`default_nettype none
interface pts_task_if import pts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [REQ_W-1:0] nice_request;
    modport source(output valid, operation, nice_request, input ready);
    modport sink(input valid, operation, nice_request, output ready);
endinterface

interface pts_result_if import pts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [PID_W-1:0]  new_pid;
    logic [PID_W-1:0]  running_pid;
    logic [PID_W-1:0]  running_parent;
    logic [TICK_W-1:0] running_ticks;
    logic              switched;
    modport source(output valid, status, new_pid, running_pid, running_parent,
                   running_ticks, switched, input ready);
    modport sink(input valid, status, new_pid, running_pid, running_parent,
                 running_ticks, switched, output ready);
endinterface

interface pts_cfg_if import pts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/priority_timeslice_scheduler_core.sv =====
// top level of the priority time-slice task scheduler
//  channel   dir  payload                                             accepted when
//  i_task    in   operation, nice_request                             valid & ready
//  o_result  out  status, new_pid, running_pid, running_parent,
//                 running_ticks, switched                             valid & ready
//  i_cfg     in   index (0 default_nice, 1 default_timeslice), data   valid & ready
// one event at a time: read of the running slot, then set nice or a tick that
// leaves slice goes on to the final read, fork scans for a free slot, and one or
// two pipelined table sweeps run when a task is chosen
// (second sweep reloads slices). a final read fills the result word.
// the result register lets the next word in while the last result waits.
// synchronous active-low reset; no clearing pass, table rows carry valid bits.
`default_nettype none
module priority_timeslice_scheduler_core import pts_pkg::*; #(
    parameter int NUM_TASKS = 15
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    pts_task_if.sink       i_task,
    pts_result_if.source   o_result,
    pts_cfg_if.sink        i_cfg
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    pts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_task.valid), .o_in_ready(i_task.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    pts_dp #(.NUM_TASKS(NUM_TASKS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_sts(sts),
        .i_op(i_task.operation), .i_nice_req(i_task.nice_request),
        .i_cfg_valid(i_cfg.valid), .i_cfg_index(i_cfg.index),
        .i_cfg_data(i_cfg.data), .o_cfg_ready(i_cfg.ready),
        .i_out_ready(o_result.ready), .o_out_valid(o_result.valid),
        .o_status(o_result.status), .o_new_pid(o_result.new_pid),
        .o_running_pid(o_result.running_pid),
        .o_running_parent(o_result.running_parent),
        .o_running_ticks(o_result.running_ticks),
        .o_switched(o_result.switched)
    );
endmodule
`default_nettype wire

// ===== rtl/pts_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/pts_ctrl.sv =====
// scheduler controller state machine
`default_nettype none
module pts_ctrl import pts_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_FREE, S_SW1, S_END1, S_SW2, S_END2, S_FRD, S_FIN
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.st_code = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.rd_cur = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                unique case (i_sts.op)
                    OP_TICK: begin
                        o_cmd.do_tick = 1'b1;
                        if (i_sts.expired) begin
                            o_cmd.sw_start = 1'b1;
                            n_state = S_SW1;
                        end else begin
                            n_state = S_FRD;
                        end
                    end
                    OP_FORK: begin
                        o_cmd.free_start = 1'b1;
                        n_state = S_FREE;
                    end
                    OP_EXIT: begin
                        if (i_sts.cur_one) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st_code = ST_REFUSED;
                            n_state = S_FRD;
                        end else begin
                            o_cmd.do_exit = 1'b1;
                            o_cmd.sw_start = 1'b1;
                            o_cmd.sw_reparent = 1'b1;
                            n_state = S_SW1;
                        end
                    end
                    OP_NICE: begin
                        o_cmd.do_nice = 1'b1;
                        n_state = S_FRD;
                    end
                    default: n_state = S_FRD;
                endcase
            end
            S_FREE: begin
                if (i_sts.free_hit) begin
                    o_cmd.fork_wr = 1'b1;
                    n_state = S_FRD;
                end else if (i_sts.free_last) begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st_code = ST_NO_SLOT;
                    n_state = S_FRD;
                end else begin
                    o_cmd.free_step = 1'b1;
                end
            end
            S_SW1: begin
                o_cmd.sw_step = 1'b1;
                if (i_sts.sw_done) n_state = S_END1;
            end
            S_END1: begin
                if (i_sts.found) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_FRD;
                end else begin
                    o_cmd.sw_start = 1'b1;
                    o_cmd.sw_reload = 1'b1;
                    n_state = S_SW2;
                end
            end
            S_SW2: begin
                o_cmd.sw_step = 1'b1;
                if (i_sts.sw_done) n_state = S_END2;
            end
            S_END2: begin
                if (i_sts.found) begin
                    o_cmd.commit = 1'b1;
                end else begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st_code = ST_NONE;
                end
                n_state = S_FRD;
            end
            S_FRD: begin
                o_cmd.rd_cur = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.rd_cur = 1'b1;
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/pts_dp.sv =====
// scheduler datapath: task table, slot scans and result register
`default_nettype none
module pts_dp import pts_pkg::*; #(
    parameter int NUM_TASKS = 15,
    localparam int PW = $clog2(NUM_TASKS + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_sts                      o_sts,
    input  wire logic [OP_W-1:0]         i_op,
    input  wire logic signed [REQ_W-1:0] i_nice_req,
    input  wire logic                    i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]    i_cfg_data,
    output logic                         o_cfg_ready,
    input  wire logic                    i_out_ready,
    output logic                         o_out_valid,
    output logic [1:0]                   o_status,
    output logic [PID_W-1:0]             o_new_pid,
    output logic [PID_W-1:0]             o_running_pid,
    output logic [PID_W-1:0]             o_running_parent,
    output logic [TICK_W-1:0]            o_running_ticks,
    output logic                         o_switched
);
    localparam int DEPTH = NUM_TASKS + 1;
    localparam logic [PW-1:0] LAST = PW'(NUM_TASKS);
    localparam logic [PW-1:0] ONE  = PW'(1);

    logic [PW-1:0]       r_cur;
    logic                r_flag;     // running slot's mode is running
    logic [DEPTH-1:0]    r_used;
    logic [DEPTH-1:0]    r_va;
    logic [DEPTH-1:0]    r_vb;
    logic [PW-1:0]       r_raq;
    t_op                 r_op;
    logic signed [REQ_W-1:0] r_req;
    t_arec               r_rec;
    logic [PW-1:0]       r_up;
    logic [PW-1:0]       r_fidx;
    logic [PW:0]         r_sidx;
    logic                r_pv;
    logic                r_reload;
    logic                r_reparent;
    logic                r_found;
    logic signed [NICE_W-1:0] r_best;
    logic [PW-1:0]       r_bidx;
    t_status             r_status;
    logic [PW-1:0]       r_newpid;
    logic                r_sw;
    logic [SLICE_W-1:0]  r_def_slice;
    logic                r_ov;

    logic [PW-1:0] raddr;
    logic          issue;
    t_arec         a_rd, a_cur, a_wd;
    logic [PW-1:0] b_rd, b_cur, b_wd;
    logic          a_we, b_we;
    logic [PW-1:0] a_wa, b_wa;
    logic          eval, elig, used_p;

    function automatic logic signed [NICE_W-1:0] clamp_nice(logic signed [REQ_W-1:0] v);
        if (v > 8'sd19) return NICE_MAX;
        if (v < -8'sd20) return NICE_MIN;
        return v[NICE_W-1:0];
    endfunction

    pts_ram #(.WIDTH($bits(t_arec)), .DEPTH(DEPTH)) u_aram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_wa), .i_wdata(a_wd),
        .i_raddr(raddr), .o_rdata(a_rd)
    );

    pts_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_bram (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_wa), .i_wdata(b_wd),
        .i_raddr(raddr), .o_rdata(b_rd)
    );

    // entries never written read as their reset value
    always_comb begin
        if (r_va[r_raq]) begin
            a_cur = a_rd;
        end else begin
            a_cur.nice  = RST_NICE;
            a_cur.slice = RST_SLICE;
            a_cur.ticks = '0;
        end
        b_cur = r_vb[r_raq] ? b_rd : ONE;
    end

    assign issue = i_cmd.sw_step && (r_sidx <= (PW+1)'(NUM_TASKS));
    assign raddr = issue ? r_sidx[PW-1:0] : r_cur;
    assign eval  = i_cmd.sw_step && r_pv;
    assign used_p = r_used[r_raq];
    assign elig  = used_p && ((r_raq != r_cur) || !r_flag) &&
                   (r_reload || (a_cur.slice != '0));

    always_comb begin
        a_we = 1'b0;
        a_wa = r_cur;
        a_wd = a_cur;
        b_we = 1'b0;
        b_wa = r_fidx;
        b_wd = r_cur;
        if (i_cmd.do_tick) begin
            a_we = 1'b1;
            a_wd.ticks = a_cur.ticks + 32'd1;
            a_wd.slice = (a_cur.slice <= 8'd1) ? '0 : a_cur.slice - 8'd1;
        end
        if (i_cmd.do_nice) begin
            a_we = 1'b1;
            a_wd.nice = clamp_nice(r_req);
        end
        if (i_cmd.fork_wr) begin
            a_we = 1'b1;
            a_wa = r_fidx;
            a_wd = r_rec;
            b_we = 1'b1;
        end
        if (eval && r_reload && used_p) begin
            a_we = 1'b1;
            a_wa = r_raq;
            a_wd.slice = r_def_slice;
        end
        if (eval && r_reparent && used_p && (r_raq != r_cur) && (b_cur == r_cur)) begin
            b_we = 1'b1;
            b_wa = r_raq;
            b_wd = r_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= ONE;
            r_flag      <= 1'b1;
            r_used      <= DEPTH'(3);
            r_va        <= '0;
            r_vb        <= '0;
            r_pv        <= 1'b0;
            r_def_slice <= RST_SLICE;
            r_ov        <= 1'b0;
        end else begin
            r_raq <= raddr;
            if (a_we) r_va[a_wa] <= 1'b1;
            if (b_we) r_vb[b_wa] <= 1'b1;
            // the nice default only matters at reset, where it is zero
            if (i_cfg_valid && (i_cfg_index == CFG_SLICE)) r_def_slice <= i_cfg_data;
            if (i_cmd.take) begin
                r_op     <= t_op'(i_op);
                r_req    <= i_nice_req;
                r_status <= ST_OK;
                r_newpid <= '0;
                r_sw     <= 1'b0;
            end
            if (i_cmd.st_we) r_status <= i_cmd.st_code;
            if (i_cmd.do_tick || i_cmd.do_nice || i_cmd.do_exit) r_rec <= a_cur;
            else if (r_op == OP_FORK && i_cmd.free_start) r_rec <= a_cur;
            if (i_cmd.do_tick && (a_cur.slice <= 8'd1)) r_flag <= 1'b0;
            if (i_cmd.do_exit) begin
                r_used[r_cur] <= 1'b0;
                r_up <= b_cur;
            end
            if (i_cmd.free_start) r_fidx <= ONE;
            if (i_cmd.free_step)  r_fidx <= r_fidx + ONE;
            if (i_cmd.fork_wr) begin
                r_used[r_fidx] <= 1'b1;
                r_newpid <= r_fidx;
                if (r_fidx == r_cur) r_flag <= 1'b0;
            end
            if (i_cmd.sw_start) begin
                r_sidx     <= (PW+1)'(1);
                r_pv       <= 1'b0;
                r_found    <= 1'b0;
                r_reload   <= i_cmd.sw_reload;
                r_reparent <= i_cmd.sw_reparent;
            end else if (i_cmd.sw_step) begin
                r_pv <= issue;
                if (issue) r_sidx <= r_sidx + (PW+1)'(1);
            end else begin
                r_pv <= 1'b0;
            end
            // strict compare keeps the lowest slot on ties
            if (eval && elig && (!r_found || (a_cur.nice < r_best))) begin
                r_found <= 1'b1;
                r_best  <= a_cur.nice;
                r_bidx  <= r_raq;
            end
            if (i_cmd.commit) begin
                r_cur  <= r_bidx;
                r_flag <= 1'b1;
                r_sw   <= 1'b1;
            end
            if (i_cmd.load_out) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status         <= r_status;
            o_new_pid        <= PID_W'(r_newpid);
            o_running_pid    <= PID_W'(r_cur);
            o_running_parent <= PID_W'(b_cur);
            o_running_ticks  <= a_cur.ticks;
            o_switched       <= r_sw;
        end
    end

    assign o_out_valid = r_ov;
    assign o_cfg_ready = 1'b1;

    assign o_sts.op        = r_op;
    assign o_sts.cur_one   = (r_cur == ONE);
    assign o_sts.expired   = (a_cur.slice <= 8'd1);
    assign o_sts.free_hit  = !r_used[r_fidx];
    assign o_sts.free_last = (r_fidx == LAST);
    assign o_sts.sw_done   = r_pv && (r_raq == LAST);
    assign o_sts.found     = r_found;
    assign o_sts.out_busy  = r_ov && !i_out_ready;
endmodule
`default_nettype wire
